// ===== rtl/tsf_pkg.sv =====
`default_nettype none
package tsf_pkg;

	localparam int POSITION_BITS = 16;
	localparam int NAME_DEPTH = 9;
	localparam int LENGTH_BITS = 8;
	localparam int NAME_IDX_BITS = $clog2(NAME_DEPTH);
	localparam int KW_COUNT = 10;
	localparam int KW_MAXLEN = 9;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [5:0] kind_t;
	typedef logic [7:0] char_t;

	localparam pos_t POS_ONE = pos_t'(1);
	localparam pos_t POS_MAX = '1;
	localparam len_t LEN_MAX = '1;

	localparam kind_t K_TILDE = 6'd10;
	localparam kind_t K_PLUS = 6'd11;
	localparam kind_t K_MINUS = 6'd12;
	localparam kind_t K_STAR = 6'd13;
	localparam kind_t K_SLASH = 6'd14;
	localparam kind_t K_PERCENT = 6'd15;
	localparam kind_t K_SHL = 6'd16;
	localparam kind_t K_SHR = 6'd17;
	localparam kind_t K_AMP = 6'd18;
	localparam kind_t K_PIPE = 6'd19;
	localparam kind_t K_CARET = 6'd20;
	localparam kind_t K_DOTAMP = 6'd21;
	localparam kind_t K_DOTPIPE = 6'd22;
	localparam kind_t K_TILDEAMP = 6'd23;
	localparam kind_t K_TILDEPIPE = 6'd24;
	localparam kind_t K_INC = 6'd25;
	localparam kind_t K_DEC = 6'd26;
	localparam kind_t K_TILDEEQ = 6'd27;
	localparam kind_t K_PLUSEQ = 6'd28;
	localparam kind_t K_MINUSEQ = 6'd29;
	localparam kind_t K_STAREQ = 6'd30;
	localparam kind_t K_SLASHEQ = 6'd31;
	localparam kind_t K_PERCENTEQ = 6'd32;
	localparam kind_t K_AMPEQ = 6'd33;
	localparam kind_t K_PIPEEQ = 6'd34;
	localparam kind_t K_CARETEQ = 6'd35;
	localparam kind_t K_SHREQ = 6'd36;
	localparam kind_t K_SHLEQ = 6'd37;
	localparam kind_t K_EQEQ = 6'd38;
	localparam kind_t K_GE = 6'd39;
	localparam kind_t K_LE = 6'd40;
	localparam kind_t K_LT = 6'd41;
	localparam kind_t K_GT = 6'd42;
	localparam kind_t K_COLON = 6'd43;
	localparam kind_t K_SEMI = 6'd44;
	localparam kind_t K_COMMA = 6'd45;
	localparam kind_t K_DOT = 6'd46;
	localparam kind_t K_LPAREN = 6'd47;
	localparam kind_t K_RPAREN = 6'd48;
	localparam kind_t K_LBRACE = 6'd49;
	localparam kind_t K_RBRACE = 6'd50;
	localparam kind_t K_ASSIGN = 6'd51;
	localparam kind_t K_IDENT = 6'd52;
	localparam kind_t K_NUMBER = 6'd53;
	localparam kind_t K_ERROR = 6'd54;
	localparam kind_t K_EOF = 6'd55;

	localparam char_t CH_TAB = 8'h09;
	localparam char_t CH_NL = 8'h0A;
	localparam char_t CH_CR = 8'h0D;
	localparam char_t CH_SP = 8'h20;
	localparam char_t CH_PERCENT = 8'h25;
	localparam char_t CH_AMP = 8'h26;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR = 8'h2A;
	localparam char_t CH_PLUS = 8'h2B;
	localparam char_t CH_COMMA = 8'h2C;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DOT = 8'h2E;
	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_D0 = 8'h30;
	localparam char_t CH_D9 = 8'h39;
	localparam char_t CH_COLON = 8'h3A;
	localparam char_t CH_SEMI = 8'h3B;
	localparam char_t CH_LT = 8'h3C;
	localparam char_t CH_EQ = 8'h3D;
	localparam char_t CH_GT = 8'h3E;
	localparam char_t CH_UA = 8'h41;
	localparam char_t CH_UZ = 8'h5A;
	localparam char_t CH_CARET = 8'h5E;
	localparam char_t CH_LA = 8'h61;
	localparam char_t CH_LZ = 8'h7A;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_BAR = 8'h7C;
	localparam char_t CH_RBRACE = 8'h7D;
	localparam char_t CH_TILDE = 8'h7E;

	localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"let", "def", "perchance", "mayhaps", "perhaps",
		"whirl", "twirl", "in", "true", "false"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd3, 4'd9, 4'd7, 4'd7, 4'd5, 4'd5, 4'd2, 4'd4, 4'd5
	};

	typedef enum logic [2:0] {
		CL_LETTER, CL_DIGIT, CL_NEWLINE, CL_BLANK, CL_OTHER
	} cls_t;

	typedef enum logic [18:0] {
		PH_IDLE    = 19'd1,
		PH_IDENT   = 19'd2,
		PH_NUMBER  = 19'd4,
		PH_COMMENT = 19'd8,
		PH_DOT     = 19'd16,
		PH_LT      = 19'd32,
		PH_SHL     = 19'd64,
		PH_GT      = 19'd128,
		PH_SHR     = 19'd256,
		PH_TILDE   = 19'd512,
		PH_PLUS    = 19'd1024,
		PH_MINUS   = 19'd2048,
		PH_STAR    = 19'd4096,
		PH_SLASH   = 19'd8192,
		PH_PERCENT = 19'd16384,
		PH_AMP     = 19'd32768,
		PH_PIPE    = 19'd65536,
		PH_CARET   = 19'd131072,
		PH_EQ      = 19'd262144
	} phase_t;

	typedef struct packed {
		char_t char_code;
		logic end_of_text;
	} item_t;

	typedef struct packed {
		item_t item;
		cls_t cls;
	} scan_t;

	typedef struct packed {
		kind_t token_kind;
		pos_t token_line;
		pos_t token_column;
		len_t token_length;
		logic last_of_run;
	} tok_t;

	typedef struct packed {
		logic hit;
		kind_t kind;
	} ck_t;

	function automatic cls_t classify(input char_t c);
		cls_t r;
		r = CL_OTHER;
		if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)) r = CL_LETTER;
		else if (c >= CH_D0 && c <= CH_D9) r = CL_DIGIT;
		else if (c == CH_NL) r = CL_NEWLINE;
		else if (c == CH_SP || c == CH_TAB || c == CH_CR) r = CL_BLANK;
		return r;
	endfunction

	function automatic pos_t sat_pos(input pos_t x);
		return (x == POS_MAX) ? x : x + POS_ONE;
	endfunction

	function automatic len_t sat_len(input len_t x);
		return (x == LEN_MAX) ? x : x + len_t'(1);
	endfunction

	function automatic kind_t ident_kind(input logic [NAME_DEPTH*8-1:0] nb, input len_t rl);
		kind_t k;
		logic m;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			m = (len_t'(KW_LEN[i]) == rl);
			for (int j = 0; j < KW_MAXLEN; j++) begin
				if (j < int'(KW_LEN[i]) &&
				    nb[j*8 +: 8] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j)*8 +: 8]) begin
					m = 1'b0;
				end
			end
			if (m) k = kind_t'(i);
		end
		return k;
	endfunction

	function automatic kind_t pending_kind(input phase_t ph);
		kind_t k;
		case (ph)
			PH_NUMBER: k = K_NUMBER;
			PH_DOT: k = K_DOT;
			PH_LT: k = K_LT;
			PH_SHL: k = K_SHL;
			PH_GT: k = K_GT;
			PH_SHR: k = K_SHR;
			PH_TILDE: k = K_TILDE;
			PH_PLUS: k = K_PLUS;
			PH_MINUS: k = K_MINUS;
			PH_STAR: k = K_STAR;
			PH_SLASH: k = K_SLASH;
			PH_PERCENT: k = K_PERCENT;
			PH_AMP: k = K_AMP;
			PH_PIPE: k = K_PIPE;
			PH_CARET: k = K_CARET;
			default: k = K_ASSIGN;
		endcase
		return k;
	endfunction

	function automatic ck_t complete_kind(input phase_t ph, input char_t c);
		ck_t r;
		logic eq;
		eq = (c == CH_EQ);
		r = '0;
		case (ph)
			PH_DOT: begin
				if (c == CH_AMP) r = '{1'b1, K_DOTAMP};
				else if (c == CH_BAR) r = '{1'b1, K_DOTPIPE};
			end
			PH_LT: if (eq) r = '{1'b1, K_LE};
			PH_SHL: if (eq) r = '{1'b1, K_SHLEQ};
			PH_GT: if (eq) r = '{1'b1, K_GE};
			PH_SHR: if (eq) r = '{1'b1, K_SHREQ};
			PH_TILDE: begin
				if (eq) r = '{1'b1, K_TILDEEQ};
				else if (c == CH_AMP) r = '{1'b1, K_TILDEAMP};
				else if (c == CH_BAR) r = '{1'b1, K_TILDEPIPE};
			end
			PH_PLUS: begin
				if (eq) r = '{1'b1, K_PLUSEQ};
				else if (c == CH_PLUS) r = '{1'b1, K_INC};
			end
			PH_MINUS: begin
				if (eq) r = '{1'b1, K_MINUSEQ};
				else if (c == CH_MINUS) r = '{1'b1, K_DEC};
			end
			PH_STAR: if (eq) r = '{1'b1, K_STAREQ};
			PH_SLASH: if (eq) r = '{1'b1, K_SLASHEQ};
			PH_PERCENT: if (eq) r = '{1'b1, K_PERCENTEQ};
			PH_AMP: if (eq) r = '{1'b1, K_AMPEQ};
			PH_PIPE: if (eq) r = '{1'b1, K_PIPEEQ};
			PH_CARET: if (eq) r = '{1'b1, K_CARETEQ};
			PH_EQ: if (eq) r = '{1'b1, K_EQEQ};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tsf_front.sv =====
`default_nettype none
module tsf_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic char_valid,
	output logic char_stall,
	input  wire tsf_pkg::item_t char_item,
	output logic scan_valid,
	output tsf_pkg::scan_t scan_item,
	input  wire logic scan_pop
);

	tsf_pkg::scan_t fq_q [2];
	logic fw_q;
	logic fr_q;
	logic [1:0] fcnt_q;
	logic push;

	assign char_stall = (fcnt_q == 2'd2);
	assign push = char_valid && !char_stall;
	assign scan_valid = (fcnt_q != 2'd0);
	assign scan_item = fq_q[fr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[fw_q] <= '{char_item, tsf_pkg::classify(char_item.char_code)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 1'b0;
			fr_q <= 1'b0;
			fcnt_q <= 2'd0;
		end else begin
			if (push) fw_q <= ~fw_q;
			if (scan_pop) fr_q <= ~fr_q;
			fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, scan_pop};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tsf_back.sv =====
`default_nettype none
module tsf_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic scan_valid,
	input  wire tsf_pkg::scan_t scan_item,
	output logic scan_pop,
	output logic tok_valid,
	input  wire logic tok_stall,
	output tsf_pkg::tok_t tok
);

	tsf_pkg::phase_t phase_q, ph_d;
	tsf_pkg::char_t nb_q [tsf_pkg::NAME_DEPTH];
	logic [tsf_pkg::NAME_DEPTH*8-1:0] nb_vec;
	tsf_pkg::pos_t sl_q, sc_q, lc_q, cc_q, sl_d, sc_d, lc_d, cc_d;
	tsf_pkg::len_t rl_q, rl_d;
	logic nb_we;
	logic [tsf_pkg::NAME_IDX_BITS-1:0] nb_idx;
	tsf_pkg::tok_t oq_q [4];
	logic [1:0] ow_q, or_q;
	logic [2:0] ocnt_q;
	tsf_pkg::tok_t tk0, tk1, tx;
	logic [1:0] en;
	logic fresh, opop, single;
	tsf_pkg::kind_t pk;
	tsf_pkg::ck_t ck;
	tsf_pkg::char_t c;
	tsf_pkg::cls_t cl;
	tsf_pkg::phase_t nph;
	tsf_pkg::kind_t sk;

	assign c = scan_item.item.char_code;
	assign cl = scan_item.cls;
	assign scan_pop = scan_valid && (ocnt_q <= 3'd2);
	assign tok_valid = (ocnt_q != 3'd0);
	assign tok = oq_q[or_q];
	assign opop = tok_valid && !tok_stall;

	always_comb begin
		for (int j = 0; j < tsf_pkg::NAME_DEPTH; j++) nb_vec[j*8 +: 8] = nb_q[j];
	end

	assign pk = (phase_q == tsf_pkg::PH_IDENT) ? tsf_pkg::ident_kind(nb_vec, rl_q)
	                                           : tsf_pkg::pending_kind(phase_q);
	assign ck = tsf_pkg::complete_kind(phase_q, c);

	always_comb begin
		ph_d = phase_q;
		sl_d = sl_q;
		sc_d = sc_q;
		lc_d = lc_q;
		cc_d = cc_q;
		rl_d = rl_q;
		nb_we = 1'b0;
		nb_idx = rl_q[tsf_pkg::NAME_IDX_BITS-1:0];
		tk0 = '0;
		tk1 = '0;
		tx = '0;
		en = 2'd0;
		fresh = 1'b0;
		single = 1'b0;
		nph = tsf_pkg::PH_IDLE;
		sk = tsf_pkg::K_ERROR;
		if (scan_pop) begin
			if (scan_item.item.end_of_text) begin
				if (phase_q != tsf_pkg::PH_IDLE && phase_q != tsf_pkg::PH_COMMENT) begin
					tk0 = '{pk, sl_q, sc_q, rl_q, 1'b0};
					en = 2'd1;
				end
				tx = '{tsf_pkg::K_EOF, lc_q, cc_q, '0, 1'b0};
				if (en == 2'd0) tk0 = tx;
				else tk1 = tx;
				en = en + 2'd1;
				ph_d = tsf_pkg::PH_IDLE;
				sl_d = tsf_pkg::POS_ONE;
				sc_d = tsf_pkg::POS_ONE;
				lc_d = tsf_pkg::POS_ONE;
				cc_d = tsf_pkg::POS_ONE;
				rl_d = '0;
			end else begin
				case (phase_q)
					tsf_pkg::PH_IDLE: fresh = 1'b1;
					tsf_pkg::PH_COMMENT: begin
						if (cl == tsf_pkg::CL_NEWLINE) begin
							ph_d = tsf_pkg::PH_IDLE;
							fresh = 1'b1;
						end else begin
							cc_d = tsf_pkg::sat_pos(cc_q);
						end
					end
					tsf_pkg::PH_IDENT: begin
						if (cl == tsf_pkg::CL_LETTER || cl == tsf_pkg::CL_DIGIT) begin
							nb_we = (32'(rl_q) < tsf_pkg::NAME_DEPTH);
							rl_d = tsf_pkg::sat_len(rl_q);
							cc_d = tsf_pkg::sat_pos(cc_q);
						end else begin
							tk0 = '{pk, sl_q, sc_q, rl_q, 1'b0};
							en = 2'd1;
							ph_d = tsf_pkg::PH_IDLE;
							fresh = 1'b1;
						end
					end
					tsf_pkg::PH_NUMBER: begin
						if (cl == tsf_pkg::CL_DIGIT) begin
							rl_d = tsf_pkg::sat_len(rl_q);
							cc_d = tsf_pkg::sat_pos(cc_q);
						end else begin
							tk0 = '{pk, sl_q, sc_q, rl_q, 1'b0};
							en = 2'd1;
							ph_d = tsf_pkg::PH_IDLE;
							fresh = 1'b1;
						end
					end
					default: begin
						if (phase_q == tsf_pkg::PH_PIPE && c == tsf_pkg::CH_BAR) begin
							ph_d = tsf_pkg::PH_COMMENT;
							cc_d = tsf_pkg::sat_pos(cc_q);
						end else if (phase_q == tsf_pkg::PH_LT && c == tsf_pkg::CH_LT) begin
							ph_d = tsf_pkg::PH_SHL;
							rl_d = tsf_pkg::sat_len(rl_q);
							cc_d = tsf_pkg::sat_pos(cc_q);
						end else if (phase_q == tsf_pkg::PH_GT && c == tsf_pkg::CH_GT) begin
							ph_d = tsf_pkg::PH_SHR;
							rl_d = tsf_pkg::sat_len(rl_q);
							cc_d = tsf_pkg::sat_pos(cc_q);
						end else if (ck.hit) begin
							rl_d = tsf_pkg::sat_len(rl_q);
							cc_d = tsf_pkg::sat_pos(cc_q);
							tk0 = '{ck.kind, sl_q, sc_q, rl_d, 1'b0};
							en = 2'd1;
							ph_d = tsf_pkg::PH_IDLE;
						end else begin
							tk0 = '{pk, sl_q, sc_q, rl_q, 1'b0};
							en = 2'd1;
							ph_d = tsf_pkg::PH_IDLE;
							fresh = 1'b1;
						end
					end
				endcase
				if (fresh) begin
					if (cl == tsf_pkg::CL_NEWLINE) begin
						lc_d = tsf_pkg::sat_pos(lc_q);
						cc_d = tsf_pkg::POS_ONE;
					end else if (cl == tsf_pkg::CL_BLANK) begin
						cc_d = tsf_pkg::sat_pos(cc_q);
					end else begin
						sl_d = lc_q;
						sc_d = cc_q;
						rl_d = tsf_pkg::len_t'(1);
						cc_d = tsf_pkg::sat_pos(cc_q);
						if (cl == tsf_pkg::CL_LETTER) begin
							nb_we = 1'b1;
							nb_idx = '0;
							ph_d = tsf_pkg::PH_IDENT;
						end else if (cl == tsf_pkg::CL_DIGIT) begin
							ph_d = tsf_pkg::PH_NUMBER;
						end else begin
							case (c)
								tsf_pkg::CH_LPAREN: begin single = 1'b1; sk = tsf_pkg::K_LPAREN; end
								tsf_pkg::CH_RPAREN: begin single = 1'b1; sk = tsf_pkg::K_RPAREN; end
								tsf_pkg::CH_LBRACE: begin single = 1'b1; sk = tsf_pkg::K_LBRACE; end
								tsf_pkg::CH_RBRACE: begin single = 1'b1; sk = tsf_pkg::K_RBRACE; end
								tsf_pkg::CH_COMMA: begin single = 1'b1; sk = tsf_pkg::K_COMMA; end
								tsf_pkg::CH_COLON: begin single = 1'b1; sk = tsf_pkg::K_COLON; end
								tsf_pkg::CH_SEMI: begin single = 1'b1; sk = tsf_pkg::K_SEMI; end
								tsf_pkg::CH_DOT: nph = tsf_pkg::PH_DOT;
								tsf_pkg::CH_LT: nph = tsf_pkg::PH_LT;
								tsf_pkg::CH_GT: nph = tsf_pkg::PH_GT;
								tsf_pkg::CH_TILDE: nph = tsf_pkg::PH_TILDE;
								tsf_pkg::CH_PLUS: nph = tsf_pkg::PH_PLUS;
								tsf_pkg::CH_MINUS: nph = tsf_pkg::PH_MINUS;
								tsf_pkg::CH_STAR: nph = tsf_pkg::PH_STAR;
								tsf_pkg::CH_SLASH: nph = tsf_pkg::PH_SLASH;
								tsf_pkg::CH_PERCENT: nph = tsf_pkg::PH_PERCENT;
								tsf_pkg::CH_AMP: nph = tsf_pkg::PH_AMP;
								tsf_pkg::CH_BAR: nph = tsf_pkg::PH_PIPE;
								tsf_pkg::CH_CARET: nph = tsf_pkg::PH_CARET;
								tsf_pkg::CH_EQ: nph = tsf_pkg::PH_EQ;
								default: begin single = 1'b1; sk = tsf_pkg::K_ERROR; end
							endcase
							if (single) begin
								tx = '{sk, lc_q, cc_q, tsf_pkg::len_t'(1), 1'b0};
								if (en == 2'd0) tk0 = tx;
								else tk1 = tx;
								en = en + 2'd1;
							end else begin
								ph_d = nph;
							end
						end
					end
				end
			end
			if (en == 2'd1) tk0.last_of_run = 1'b1;
			if (en == 2'd2) tk1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (nb_we) nb_q[nb_idx] <= c;
		if (en != 2'd0) oq_q[ow_q] <= tk0;
		if (en == 2'd2) oq_q[ow_q + 2'd1] <= tk1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsf_pkg::PH_IDLE;
			sl_q <= tsf_pkg::POS_ONE;
			sc_q <= tsf_pkg::POS_ONE;
			lc_q <= tsf_pkg::POS_ONE;
			cc_q <= tsf_pkg::POS_ONE;
			rl_q <= '0;
			ow_q <= 2'd0;
			or_q <= 2'd0;
			ocnt_q <= 3'd0;
		end else begin
			phase_q <= ph_d;
			sl_q <= sl_d;
			sc_q <= sc_d;
			lc_q <= lc_d;
			cc_q <= cc_d;
			rl_q <= rl_d;
			ow_q <= ow_q + en;
			if (opop) or_q <= or_q + 2'd1;
			ocnt_q <= ocnt_q + {1'b0, en} - {2'b0, opop};
		end
	end

	a_ocnt: assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= 3'd4)
		else $error("Token queue overflow.");
	a_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_pop && scan_item.item.end_of_text) |=>
		(phase_q == tsf_pkg::PH_IDLE && lc_q == tsf_pkg::POS_ONE && cc_q == tsf_pkg::POS_ONE))
		else $error("End of text did not restore the initial state.");
	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		(en == 2'd2) |-> (phase_q != tsf_pkg::PH_IDLE))
		else $error("Two tokens from an idle scanner.");

endmodule
`default_nettype wire

// ===== rtl/token_scanner_fsm.sv =====
// A character passes the input queue and then the token queue before its token reaches the output.
// Throughput: one character per cycle while the token queue has room; a character that yields
// two tokens writes both at once, and the four-entry token queue stalls input when nearly full.
// The two-entry input queue sets the stall, which depends only on registered state.
// Reset (arst_n low, asynchronous) empties both queues and returns to line 1, column 1.
`default_nettype none
module token_scanner_fsm (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic char_valid,
	output logic char_stall,
	input  wire tsf_pkg::item_t char_item,
	output logic tok_valid,
	input  wire logic tok_stall,
	output tsf_pkg::tok_t tok
);

	logic scan_valid;
	logic scan_pop;
	tsf_pkg::scan_t scan_item;

	tsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item(char_item),
		.scan_valid(scan_valid),
		.scan_item(scan_item),
		.scan_pop(scan_pop)
	);

	tsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.scan_valid(scan_valid),
		.scan_item(scan_item),
		.scan_pop(scan_pop),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok(tok)
	);

endmodule
`default_nettype wire
